/* hw/rtl/svs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_pkg
// Shared widths, constants, types and tables of the sprite quad vertex setup.
// ----------------------------------------------------------------------------
package svs_pkg;

    // coordinate fraction bits of positions, sizes and texture edges
    localparam int C_FRAC = 8;

    // field widths
    localparam int C_POS_W   = 24;
    localparam int C_SCALE_W = 16;
    localparam int C_ANG_W   = 17;
    localparam int C_REG_W   = 16;
    localparam int C_CFG_W   = 24;
    localparam int C_IDX_W   = 3;
    localparam int C_OUT_W   = 16;

    // internal widths
    localparam int C_D_W    = C_REG_W + C_FRAC;   // screen or texture size in coord units
    localparam int C_DEN_W  = C_D_W + 1;          // divisor, twice the size
    localparam int C_DIV_W  = C_DEN_W + C_OUT_W;  // remainder width inside the divider
    localparam int C_CS_W   = 20;                 // cosine and sine
    localparam int C_Z_W    = 25;                 // cordic angle accumulator
    localparam int C_SZ_W   = 32;                 // scaled size
    localparam int C_PU_W   = 34;                 // pivot offset
    localparam int C_OFF_W  = 35;                 // corner offset from pivot
    localparam int C_PRD_W  = C_OFF_W + C_CS_W;   // rotation product
    localparam int C_SUM_W  = C_PRD_W + 1;
    localparam int C_RND_W  = C_SUM_W - 16;       // rotated offset after rounding
    localparam int C_X_W    = C_RND_W + 1;        // rotated screen coordinate
    localparam int C_NUM_W  = C_X_W + 17;         // divider numerator

    // cordic
    localparam int C_STEPS    = 16;
    localparam int C_TRIG_LAT = C_STEPS + 2;
    localparam logic signed [C_CS_W-1:0] C_GAIN_INV = 20'sd39797;
    localparam logic [22:0] C_ATAN [0:C_STEPS-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

    // angle turns in 1/128 degree
    localparam logic signed [C_ANG_W:0] C_FULL_TURN    = 18'sd46080;
    localparam logic signed [C_ANG_W:0] C_HALF_TURN    = 18'sd23040;
    localparam logic signed [C_ANG_W:0] C_QUARTER_TURN = 18'sd11520;

    // register indexes
    localparam logic [C_IDX_W-1:0] C_REG_SCREEN_W = 3'd0;
    localparam logic [C_IDX_W-1:0] C_REG_SCREEN_H = 3'd1;
    localparam logic [C_IDX_W-1:0] C_REG_TEX_W    = 3'd2;
    localparam logic [C_IDX_W-1:0] C_REG_TEX_H    = 3'd3;
    localparam logic [C_IDX_W-1:0] C_REG_PIVOT_U  = 3'd4;
    localparam logic [C_IDX_W-1:0] C_REG_PIVOT_V  = 3'd5;
    localparam logic [C_IDX_W-1:0] C_REG_SHAKE_X  = 3'd6;
    localparam logic [C_IDX_W-1:0] C_REG_SHAKE_Y  = 3'd7;

    // corner codes
    localparam logic [1:0] C_CORNER_LT = 2'd0;
    localparam logic [1:0] C_CORNER_RT = 2'd1;
    localparam logic [1:0] C_CORNER_LB = 2'd2;
    localparam logic [1:0] C_CORNER_RB = 2'd3;

    // saturation codes
    localparam logic [C_OUT_W-1:0] C_SAT_MAX_S = 16'h7FFF;
    localparam logic [C_OUT_W-1:0] C_SAT_MIN_S = 16'h8000;
    localparam logic [C_OUT_W-1:0] C_SAT_MAX_U = 16'hFFFF;

    typedef struct packed {
        logic [C_POS_W-1:0]   pos_x;
        logic [C_POS_W-1:0]   pos_y;
        logic [C_POS_W-1:0]   size_w;
        logic [C_POS_W-1:0]   size_h;
        logic [C_SCALE_W-1:0] scale_x;
        logic [C_SCALE_W-1:0] scale_y;
        logic [C_POS_W-1:0]   tex_x;
        logic [C_POS_W-1:0]   tex_y;
        logic [C_POS_W-1:0]   tex_w;
        logic [C_POS_W-1:0]   tex_h;
        logic [C_ANG_W-1:0]   angle;
    } t_item;

    typedef struct packed {
        logic [C_REG_W-1:0] screen_w;
        logic [C_REG_W-1:0] screen_h;
        logic [C_REG_W-1:0] tex_full_w;
        logic [C_REG_W-1:0] tex_full_h;
        logic [C_REG_W-1:0] pivot_u;
        logic [C_REG_W-1:0] pivot_v;
        logic [C_POS_W-1:0] shake_x;
        logic [C_POS_W-1:0] shake_y;
    } t_cfg;

    // numerators of one corner leaving the geometry pipe
    typedef struct packed {
        logic               valid;
        logic [1:0]         corner;
        logic [C_NUM_W-1:0] n_x;
        logic [C_NUM_W-1:0] n_y;
        logic [C_NUM_W-1:0] n_u;
        logic [C_NUM_W-1:0] n_v;
    } t_num;

    // divider result with out-of-range flags
    typedef struct packed {
        logic               low;
        logic               high;
        logic [C_OUT_W-1:0] q;
    } t_divres;

    // size register in coordinate units, zero read as one
    function automatic logic [C_D_W-1:0] f_dscale(input logic [C_REG_W-1:0] r);
        logic [C_REG_W-1:0] v;
        v = (r == '0) ? C_REG_W'(1) : r;
        return {v, {C_FRAC{1'b0}}};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/svs_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_in_if
// Draw request channel: valid, ready and the request fields.
// ----------------------------------------------------------------------------
interface svs_in_if;
    logic                            valid;
    logic                            ready;
    logic [svs_pkg::C_POS_W-1:0]     pos_x;
    logic [svs_pkg::C_POS_W-1:0]     pos_y;
    logic [svs_pkg::C_POS_W-1:0]     size_w;
    logic [svs_pkg::C_POS_W-1:0]     size_h;
    logic [svs_pkg::C_SCALE_W-1:0]   scale_x;
    logic [svs_pkg::C_SCALE_W-1:0]   scale_y;
    logic [svs_pkg::C_POS_W-1:0]     tex_x;
    logic [svs_pkg::C_POS_W-1:0]     tex_y;
    logic [svs_pkg::C_POS_W-1:0]     tex_w;
    logic [svs_pkg::C_POS_W-1:0]     tex_h;
    logic [svs_pkg::C_ANG_W-1:0]     angle;

    modport source (
        output valid, pos_x, pos_y, size_w, size_h, scale_x, scale_y,
               tex_x, tex_y, tex_w, tex_h, angle,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, size_w, size_h, scale_x, scale_y,
               tex_x, tex_y, tex_w, tex_h, angle,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/svs_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_out_if
// Corner result channel: valid, ready and the corner fields.
// ----------------------------------------------------------------------------
interface svs_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    corner;
    logic [svs_pkg::C_OUT_W-1:0]   ndc_x;
    logic [svs_pkg::C_OUT_W-1:0]   ndc_y;
    logic [svs_pkg::C_OUT_W-1:0]   tex_u;
    logic [svs_pkg::C_OUT_W-1:0]   tex_v;
    logic                          last;

    modport source (
        output valid, corner, ndc_x, ndc_y, tex_u, tex_v, last,
        input  ready
    );
    modport sink (
        input  valid, corner, ndc_x, ndc_y, tex_u, tex_v, last,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/svs_sincos.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_sincos
// Pipelined cordic: angle reduction, sixteen rotation stages, sign fix-up.
// ----------------------------------------------------------------------------
module svs_sincos (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [svs_pkg::C_ANG_W-1:0]       i_angle,
    output logic signed [svs_pkg::C_CS_W-1:0]      o_cos,
    output logic signed [svs_pkg::C_CS_W-1:0]      o_sin
);

    localparam int N = svs_pkg::C_STEPS;

    logic signed [svs_pkg::C_ANG_W:0]    w_a;
    logic signed [svs_pkg::C_ANG_W:0]    w_r;
    logic signed [svs_pkg::C_ANG_W:0]    w_f;
    logic                                w_neg;

    logic signed [svs_pkg::C_CS_W-1:0]   r_x   [0:N];
    logic signed [svs_pkg::C_CS_W-1:0]   r_y   [0:N];
    logic signed [svs_pkg::C_Z_W-1:0]    r_z   [0:N];
    logic                                r_neg [0:N];

    // reduce to one turn, then fold into the right half plane
    always_comb begin
        w_a   = {i_angle[svs_pkg::C_ANG_W-1], i_angle};
        w_neg = 1'b0;
        if (w_a >= svs_pkg::C_HALF_TURN) begin
            w_r = w_a - svs_pkg::C_FULL_TURN;
        end else if (w_a < -svs_pkg::C_HALF_TURN) begin
            w_r = w_a + svs_pkg::C_FULL_TURN;
        end else begin
            w_r = w_a;
        end
        if (w_r > svs_pkg::C_QUARTER_TURN) begin
            w_f   = w_r - svs_pkg::C_HALF_TURN;
            w_neg = 1'b1;
        end else if (w_r < -svs_pkg::C_QUARTER_TURN) begin
            w_f   = w_r + svs_pkg::C_HALF_TURN;
            w_neg = 1'b1;
        end else begin
            w_f = w_r;
        end
    end

    // first stage: start vector and angle in cordic units
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= svs_pkg::C_GAIN_INV;
            r_y[0]   <= '0;
            r_z[0]   <= svs_pkg::C_Z_W'(w_f) <<< 9;
            r_neg[0] <= w_neg;
        end
    end

    // one rotation step per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][svs_pkg::C_Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - svs_pkg::C_Z_W'(svs_pkg::C_ATAN[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + svs_pkg::C_Z_W'(svs_pkg::C_ATAN[i]);
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[N] ? -r_x[N] : r_x[N];
            o_sin <= r_neg[N] ? -r_y[N] : r_y[N];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/svs_geom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_geom
// Corner geometry pipe: scaled size, pivot offsets, rotation and the
// numerators of the screen and texture divisions.
// ----------------------------------------------------------------------------
module svs_geom (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [1:0]                        i_corner,
    input  wire svs_pkg::t_item                    i_item,
    input  wire svs_pkg::t_cfg                     i_cfg,
    input  wire logic signed [svs_pkg::C_CS_W-1:0] i_cos,
    input  wire logic signed [svs_pkg::C_CS_W-1:0] i_sin,
    output svs_pkg::t_num                          o_num
);

    localparam int C_DLY = svs_pkg::C_TRIG_LAT - 4;

    typedef struct packed {
        logic [1:0]                          corner;
        logic signed [svs_pkg::C_OFF_W-1:0]  ox;
        logic signed [svs_pkg::C_OFF_W-1:0]  oy;
        logic signed [svs_pkg::C_POS_W:0]    cx;
        logic signed [svs_pkg::C_POS_W:0]    cy;
        logic [svs_pkg::C_POS_W:0]           tu;
        logic [svs_pkg::C_POS_W:0]           tv;
    } t_dly;

    typedef struct packed {
        logic [1:0]                          corner;
        logic signed [svs_pkg::C_POS_W:0]    cx;
        logic signed [svs_pkg::C_POS_W:0]    cy;
        logic [svs_pkg::C_POS_W:0]           tu;
        logic [svs_pkg::C_POS_W:0]           tv;
    } t_side;

    // valid chain
    logic r_v1, r_v2, r_v3, r_v4, r_v19, r_v20, r_v21;
    logic r_dly_v [0:C_DLY-1];

    // stage payloads
    t_side                               r_s1, r_s2, r_s3, r_s4, r_s19, r_s20, r_s21;
    logic signed [39:0]                  r_pw, r_ph;
    logic signed [svs_pkg::C_SZ_W-1:0]   r_sw2, r_sh2, r_sw3, r_sh3, r_sw4, r_sh4;
    logic signed [48:0]                  r_qu, r_qv;
    logic signed [svs_pkg::C_PU_W-1:0]   r_pu, r_pv;
    t_dly                                r_dly [0:C_DLY-1];
    logic signed [svs_pkg::C_PRD_W-1:0]  r_mxc, r_mys, r_myc, r_mxs;
    logic signed [svs_pkg::C_SUM_W-1:0]  r_ax, r_ay;
    logic signed [svs_pkg::C_X_W-1:0]    r_gx, r_gy;

    logic signed [39:0]                  w_pw_r, w_ph_r;
    logic signed [48:0]                  w_qu_r, w_qv_r;
    logic signed [svs_pkg::C_OFF_W-1:0]  w_swx, w_shx, w_pux, w_pvx;
    logic [svs_pkg::C_RND_W-1:0]         w_rx, w_ry;
    logic [svs_pkg::C_D_W-1:0]           w_dw, w_dh, w_du, w_dv;
    logic [svs_pkg::C_D_W+15:0]          w_kx, w_ky;
    logic [svs_pkg::C_POS_W+16:0]        w_nu, w_nv;
    t_side                               w_s1;

    // rounding adds ahead of the narrowing shifts
    always_comb begin
        w_pw_r = r_pw + 40'sd128;
        w_ph_r = r_ph + 40'sd128;
        w_qu_r = r_qu + 49'sd16384;
        w_qv_r = r_qv + 49'sd16384;
        w_swx  = svs_pkg::C_OFF_W'(r_sw4);
        w_shx  = svs_pkg::C_OFF_W'(r_sh4);
        w_pux  = svs_pkg::C_OFF_W'(r_pu);
        w_pvx  = svs_pkg::C_OFF_W'(r_pv);
        w_rx   = r_ax[svs_pkg::C_SUM_W-1:16];
        w_ry   = r_ay[svs_pkg::C_SUM_W-1:16];
    end

    // pivot point and texture edge of this corner (bit 0 right, bit 1 bottom)
    always_comb begin
        w_s1.corner = i_corner;
        w_s1.cx = {i_item.pos_x[svs_pkg::C_POS_W-1], i_item.pos_x}
                - {i_cfg.shake_x[svs_pkg::C_POS_W-1], i_cfg.shake_x};
        w_s1.cy = {i_item.pos_y[svs_pkg::C_POS_W-1], i_item.pos_y}
                - {i_cfg.shake_y[svs_pkg::C_POS_W-1], i_cfg.shake_y};
        w_s1.tu = i_corner[0] ? ({1'b0, i_item.tex_x} + {1'b0, i_item.tex_w})
                              : {1'b0, i_item.tex_x};
        w_s1.tv = i_corner[1] ? ({1'b0, i_item.tex_y} + {1'b0, i_item.tex_h})
                              : {1'b0, i_item.tex_y};
    end

    // division numerators
    always_comb begin
        w_dw = svs_pkg::f_dscale(i_cfg.screen_w);
        w_dh = svs_pkg::f_dscale(i_cfg.screen_h);
        w_du = svs_pkg::f_dscale(i_cfg.tex_full_w);
        w_dv = svs_pkg::f_dscale(i_cfg.tex_full_h);
        // 32769 and 32767 times the screen size fold in the rounding and offsets
        w_kx = {1'b0, w_dw, 15'b0} + {16'b0, w_dw};
        w_ky = {1'b0, w_dh, 15'b0} - {16'b0, w_dh};
        w_nu = {1'b0, r_s21.tu, 15'b0} + (svs_pkg::C_POS_W + 17)'(w_du);
        w_nv = {1'b0, r_s21.tv, 15'b0} + (svs_pkg::C_POS_W + 17)'(w_dv);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int k = 0; k < C_DLY; k++) r_dly_v[k] <= 1'b0;
            r_v19 <= 1'b0;
            r_v20 <= 1'b0;
            r_v21 <= 1'b0;
            o_num.valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_dly_v[0] <= r_v4;
            for (int k = 1; k < C_DLY; k++) r_dly_v[k] <= r_dly_v[k-1];
            r_v19 <= r_dly_v[C_DLY-1];
            r_v20 <= r_v19;
            r_v21 <= r_v20;
            o_num.valid <= r_v21;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // scale products
            r_s1 <= w_s1;
            r_pw <= $signed(i_item.size_w) * $signed(i_item.scale_x);
            r_ph <= $signed(i_item.size_h) * $signed(i_item.scale_y);
            // scaled size
            r_s2  <= r_s1;
            r_sw2 <= w_pw_r[39:8];
            r_sh2 <= w_ph_r[39:8];
            // pivot products
            r_s3  <= r_s2;
            r_sw3 <= r_sw2;
            r_sh3 <= r_sh2;
            r_qu  <= r_sw2 * $signed({1'b0, i_cfg.pivot_u});
            r_qv  <= r_sh2 * $signed({1'b0, i_cfg.pivot_v});
            // pivot offsets
            r_s4  <= r_s3;
            r_sw4 <= r_sw3;
            r_sh4 <= r_sh3;
            r_pu  <= w_qu_r[48:15];
            r_pv  <= w_qv_r[48:15];
            // corner offsets, then wait for the cordic
            r_dly[0].corner <= r_s4.corner;
            r_dly[0].ox <= r_s4.corner[0] ? (w_swx - w_pux) : -w_pux;
            r_dly[0].oy <= r_s4.corner[1] ? (w_shx - w_pvx) : -w_pvx;
            r_dly[0].cx <= r_s4.cx;
            r_dly[0].cy <= r_s4.cy;
            r_dly[0].tu <= r_s4.tu;
            r_dly[0].tv <= r_s4.tv;
            for (int k = 1; k < C_DLY; k++) r_dly[k] <= r_dly[k-1];
            // rotation products
            r_s19.corner <= r_dly[C_DLY-1].corner;
            r_s19.cx <= r_dly[C_DLY-1].cx;
            r_s19.cy <= r_dly[C_DLY-1].cy;
            r_s19.tu <= r_dly[C_DLY-1].tu;
            r_s19.tv <= r_dly[C_DLY-1].tv;
            r_mxc <= $signed(r_dly[C_DLY-1].ox) * i_cos;
            r_mys <= $signed(r_dly[C_DLY-1].oy) * i_sin;
            r_myc <= $signed(r_dly[C_DLY-1].oy) * i_cos;
            r_mxs <= $signed(r_dly[C_DLY-1].ox) * i_sin;
            // rotation sums with rounding term
            r_s20 <= r_s19;
            r_ax <= svs_pkg::C_SUM_W'(r_mxc) - svs_pkg::C_SUM_W'(r_mys) + 56'sd32768;
            r_ay <= svs_pkg::C_SUM_W'(r_myc) + svs_pkg::C_SUM_W'(r_mxs) + 56'sd32768;
            // rotated corner on screen
            r_s21 <= r_s20;
            r_gx <= svs_pkg::C_X_W'($signed(r_s20.cx)) + svs_pkg::C_X_W'($signed(w_rx));
            r_gy <= svs_pkg::C_X_W'($signed(r_s20.cy)) + svs_pkg::C_X_W'($signed(w_ry));
            // numerators
            o_num.corner <= r_s21.corner;
            o_num.n_x <= svs_pkg::C_NUM_W'($signed({r_gx, 16'b0}))
                       + svs_pkg::C_NUM_W'(w_kx);
            o_num.n_y <= svs_pkg::C_NUM_W'($signed({r_gy, 16'b0}))
                       + svs_pkg::C_NUM_W'(w_ky);
            o_num.n_u <= svs_pkg::C_NUM_W'(w_nu);
            o_num.n_v <= svs_pkg::C_NUM_W'(w_nv);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/svs_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svs_div
// Pipelined restoring divider: range check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module svs_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [svs_pkg::C_NUM_W-1:0]    i_num,
    input  wire logic [svs_pkg::C_DEN_W-1:0]    i_den,
    output svs_pkg::t_divres                    o_res
);

    localparam int NB = svs_pkg::C_OUT_W;

    logic [svs_pkg::C_NUM_W-1:0]   w_lim;
    logic                          w_low;
    logic                          w_high;

    logic [svs_pkg::C_DIV_W-1:0]   r_rem [0:NB];
    logic [NB-1:0]                 r_q   [0:NB];
    logic                          r_lo  [0:NB];
    logic                          r_hi  [0:NB];

    // quotient out of range below zero or at or above the field span
    always_comb begin
        w_lim  = svs_pkg::C_NUM_W'({i_den, {NB{1'b0}}});
        w_low  = i_num[svs_pkg::C_NUM_W-1];
        w_high = !w_low && (i_num >= w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[svs_pkg::C_DIV_W-1:0];
            r_q[0]   <= '0;
            r_lo[0]  <= w_low;
            r_hi[0]  <= w_high;
        end
    end

    // quotient bits, most significant first
    for (genvar j = 0; j < NB; j++) begin : g_bit
        localparam int B = NB - 1 - j;
        logic [svs_pkg::C_DIV_W-1:0] w_sub;
        logic                        w_ge;
        always_comb begin
            w_sub = svs_pkg::C_DIV_W'(i_den) << B;
            w_ge  = r_rem[j] >= w_sub;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? (r_rem[j] - w_sub) : r_rem[j];
                r_q[j+1]   <= {r_q[j][NB-2:0], w_ge};
                r_lo[j+1]  <= r_lo[j];
                r_hi[j+1]  <= r_hi[j];
            end
        end
    end

    assign o_res.low  = r_lo[NB];
    assign o_res.high = r_hi[NB];
    assign o_res.q    = r_q[NB];

endmodule
`default_nettype wire

/* hw/rtl/sprite_quad_vertex_setup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Turns one sprite draw request into its four quad corners in screen NDC
// with normalised texture coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries draw requests, o_out carries corner items, both valid/ready.
//   Each request gives four corner items in the order left-top, right-top,
//   left-bottom, right-bottom; last marks the fourth.
//   A request is taken into the single corner issue slot, which feeds the
//   pipeline one corner a cycle while the pipeline is not stalled; a new
//   request is taken in the cycle its predecessor's last corner is issued.
//   The pipeline is cordic for sine and cosine (18 stages) in parallel with
//   the size, pivot and rotation stages, then four 17-stage dividers.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while no
//   request is in flight.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults. With o_out.valid high and o_out.ready low the whole
//   pipeline holds, nothing is dropped, and i_in.ready is low with a full slot.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    svs_in_if.sink                               i_in,
    svs_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [svs_pkg::C_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [svs_pkg::C_CFG_W-1:0]     i_cfg_data
);

    localparam int NB = svs_pkg::C_OUT_W;

    svs_pkg::t_cfg                      r_cfg;
    svs_pkg::t_item                     r_hold;
    logic                               r_hold_valid;
    logic [1:0]                         r_cnt;
    logic                               r_tag_v [0:NB];
    logic [1:0]                         r_tag_k [0:NB];
    logic                               r_out_valid;

    logic                               w_en;
    logic                               w_accept;
    svs_pkg::t_item                     w_item;
    logic signed [svs_pkg::C_CS_W-1:0]  w_cos, w_sin;
    svs_pkg::t_num                      w_num;
    svs_pkg::t_divres                   w_rx, w_ry, w_ru, w_rv;
    logic [svs_pkg::C_DEN_W-1:0]        w_den_x, w_den_y, w_den_u, w_den_v;
    logic [NB-1:0]                      w_ndc_x, w_ndc_y, w_tex_u, w_tex_v;

    // pipeline advances whenever the output register can move
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_hold_valid || (w_en && (r_cnt == svs_pkg::C_CORNER_RB));
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        w_item.pos_x   = i_in.pos_x;
        w_item.pos_y   = i_in.pos_y;
        w_item.size_w  = i_in.size_w;
        w_item.size_h  = i_in.size_h;
        w_item.scale_x = i_in.scale_x;
        w_item.scale_y = i_in.scale_y;
        w_item.tex_x   = i_in.tex_x;
        w_item.tex_y   = i_in.tex_y;
        w_item.tex_w   = i_in.tex_w;
        w_item.tex_h   = i_in.tex_h;
        w_item.angle   = i_in.angle;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_w   <= 16'd1920;
            r_cfg.screen_h   <= 16'd1080;
            r_cfg.tex_full_w <= 16'd256;
            r_cfg.tex_full_h <= 16'd256;
            r_cfg.pivot_u    <= 16'd16384;
            r_cfg.pivot_v    <= 16'd16384;
            r_cfg.shake_x    <= '0;
            r_cfg.shake_y    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svs_pkg::C_REG_SCREEN_W: r_cfg.screen_w   <= i_cfg_data[15:0];
                svs_pkg::C_REG_SCREEN_H: r_cfg.screen_h   <= i_cfg_data[15:0];
                svs_pkg::C_REG_TEX_W:    r_cfg.tex_full_w <= i_cfg_data[15:0];
                svs_pkg::C_REG_TEX_H:    r_cfg.tex_full_h <= i_cfg_data[15:0];
                svs_pkg::C_REG_PIVOT_U:  r_cfg.pivot_u    <= i_cfg_data[15:0];
                svs_pkg::C_REG_PIVOT_V:  r_cfg.pivot_v    <= i_cfg_data[15:0];
                svs_pkg::C_REG_SHAKE_X:  r_cfg.shake_x    <= i_cfg_data;
                svs_pkg::C_REG_SHAKE_Y:  r_cfg.shake_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request holding slot and corner issue counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_cnt        <= svs_pkg::C_CORNER_LT;
        end else begin
            if (r_hold_valid && w_en) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == svs_pkg::C_CORNER_RB) r_hold_valid <= w_accept;
            end else if (w_accept) begin
                r_hold_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_hold <= w_item;
    end

    svs_sincos u_sincos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_hold.angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    svs_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_hold_valid),
        .i_corner (r_cnt),
        .i_item   (r_hold),
        .i_cfg    (r_cfg),
        .i_cos    (w_cos),
        .i_sin    (w_sin),
        .o_num    (w_num)
    );

    // divisors are twice the sizes in coordinate units
    always_comb begin
        w_den_x = {svs_pkg::f_dscale(r_cfg.screen_w), 1'b0};
        w_den_y = {svs_pkg::f_dscale(r_cfg.screen_h), 1'b0};
        w_den_u = {svs_pkg::f_dscale(r_cfg.tex_full_w), 1'b0};
        w_den_v = {svs_pkg::f_dscale(r_cfg.tex_full_h), 1'b0};
    end

    svs_div u_div_x (.i_clk(i_clk), .i_en(w_en), .i_num(w_num.n_x), .i_den(w_den_x),
                     .o_res(w_rx));
    svs_div u_div_y (.i_clk(i_clk), .i_en(w_en), .i_num(w_num.n_y), .i_den(w_den_y),
                     .o_res(w_ry));
    svs_div u_div_u (.i_clk(i_clk), .i_en(w_en), .i_num(w_num.n_u), .i_den(w_den_u),
                     .o_res(w_ru));
    svs_div u_div_v (.i_clk(i_clk), .i_en(w_en), .i_num(w_num.n_v), .i_den(w_den_v),
                     .o_res(w_rv));

    // valid and corner alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NB; k++) r_tag_v[k] <= 1'b0;
        end else if (w_en) begin
            r_tag_v[0] <= w_num.valid;
            for (int k = 1; k <= NB; k++) r_tag_v[k] <= r_tag_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag_k[0] <= w_num.corner;
            for (int k = 1; k <= NB; k++) r_tag_k[k] <= r_tag_k[k-1];
        end
    end

    // quotients carry offsets, so the sign flip and saturation are bit ops
    always_comb begin
        w_ndc_x = w_rx.low ? svs_pkg::C_SAT_MIN_S :
                  w_rx.high ? svs_pkg::C_SAT_MAX_S : (w_rx.q ^ svs_pkg::C_SAT_MIN_S);
        w_ndc_y = w_ry.low ? svs_pkg::C_SAT_MAX_S :
                  w_ry.high ? svs_pkg::C_SAT_MIN_S : (w_ry.q ^ svs_pkg::C_SAT_MAX_S);
        w_tex_u = w_ru.high ? svs_pkg::C_SAT_MAX_U : w_ru.q;
        w_tex_v = w_rv.high ? svs_pkg::C_SAT_MAX_U : w_rv.q;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_tag_v[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out.corner <= r_tag_k[NB];
            o_out.last   <= (r_tag_k[NB] == svs_pkg::C_CORNER_RB);
            o_out.ndc_x  <= w_ndc_x;
            o_out.ndc_y  <= w_ndc_y;
            o_out.tex_u  <= w_tex_u;
            o_out.tex_v  <= w_tex_v;
        end
    end

    assign o_out.valid = r_out_valid;

    // an empty slot always restarts at the first corner
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hold_valid |-> r_cnt == svs_pkg::C_CORNER_LT)
        else $error("corner counter not at first corner with empty slot");

    // the issue counter only moves with the pipeline
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_hold_valid) |=> $stable(r_cnt))
        else $error("corner counter moved during a stall");

    // corners of one quad leave back to back, in order
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.corner != svs_pkg::C_CORNER_RB)
        |=> (o_out.valid && (o_out.corner == $past(o_out.corner) + 2'd1)))
        else $error("quad corners not contiguous");

endmodule
`default_nettype wire
